[sv/ctf_pkg.sv]
package ctf_pkg;

	localparam int TableLen = 24;
	localparam int AngW = 32;
	// cordic working width: 16-bit input scaled by 256, growth below 2x
	localparam int CordW = 27;
	localparam int ZW = 26;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_GYRO  = 5'b00010,
		ST_CORD  = 5'b00100,
		ST_BLEND = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	localparam logic [1:0] REG_GAIN = 2'd0;
	localparam logic [1:0] REG_WEIGHT = 2'd1;
	localparam logic [1:0] REG_LOW = 2'd2;
	localparam logic [1:0] REG_HIGH = 2'd3;

	function automatic logic [ZW-1:0] atan_tab(input logic [4:0] i);
		logic [ZW-1:0] r;
		case (i)
			5'd0: r = 26'd2949120;
			5'd1: r = 26'd1740967;
			5'd2: r = 26'd919879;
			5'd3: r = 26'd466945;
			5'd4: r = 26'd234379;
			5'd5: r = 26'd117304;
			5'd6: r = 26'd58666;
			5'd7: r = 26'd29335;
			5'd8: r = 26'd14668;
			5'd9: r = 26'd7334;
			5'd10: r = 26'd3667;
			5'd11: r = 26'd1833;
			5'd12: r = 26'd917;
			5'd13: r = 26'd458;
			5'd14: r = 26'd229;
			5'd15: r = 26'd115;
			5'd16: r = 26'd57;
			5'd17: r = 26'd29;
			5'd18: r = 26'd14;
			5'd19: r = 26'd7;
			5'd20: r = 26'd4;
			5'd21: r = 26'd2;
			5'd22: r = 26'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [AngW-1:0] sat32(input logic signed [63:0] v);
		logic signed [AngW-1:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[AngW-1:0];
		return r;
	endfunction

endpackage

[sv/complementary_tilt_filter.sv]
// one item at a time: a gyro step always, then cordic and blend steps only when the correction applies;
// next item taken in the cycle after the result leaves
// pitch and roll cordic lanes run side by side, one step per cycle each
// gyro and angle*weight products built one multiplier bit per cycle into an accumulator
// arst_n clears angles to zero and loads register reset values
module complementary_tilt_filter #(
	parameter int ATAN_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] pitch_angle,
	output logic signed [31:0] roll_angle,
	output logic        corrected,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	localparam int NIter = (ATAN_ITERATIONS > ctf_pkg::TableLen) ? ctf_pkg::TableLen
		: ATAN_ITERATIONS;
	localparam int CW = ctf_pkg::CordW;
	localparam int ZW = ctf_pkg::ZW;

	ctf_pkg::state_t state_q;
	logic [5:0] cnt_q;

	// configuration registers
	logic [23:0] gain_q;
	logic [16:0] weight_q, low_q, high_q;

	// stored angles
	logic signed [31:0] pitch_q, roll_q;

	// sample registers
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
	logic apply_q;

	// serial multiplier: multiplier bits shift out lsb first, two lanes in parallel
	logic [23:0] msr_q;                 // gain bits for gyro step
	logic signed [48:0] pacc_q, racc_q; // lane accumulators

	// cordic state for both lanes (pitch uses ay/az, roll uses ax/az)
	logic signed [CW-1:0] px_q, py_q, rx_q, ry_q;
	logic signed [ZW-1:0] pz_q, rz_q;

	logic [16:0] wsr_q; // weight bits for blend

	logic [17:0] mag;
	logic [16:0] wsat;
	logic signed [17:0] wacc;

	always_comb begin
		mag = 18'(ax_q[15] ? -{{2{ax_q[15]}}, ax_q} : {2'b0, ax_q})
			+ 18'(ay_q[15] ? -{{2{ay_q[15]}}, ay_q} : {2'b0, ay_q})
			+ 18'(az_q[15] ? -{{2{az_q[15]}}, az_q} : {2'b0, az_q});
		wsat = (weight_q > 17'd65536) ? 17'd65536 : weight_q;
		wacc = 18'sd65536 - $signed({1'b0, wsat});
	end

	assign in_stall = (state_q != ctf_pkg::ST_IDLE);
	assign out_valid = (state_q == ctf_pkg::ST_OUT);
	assign pitch_angle = pitch_q;
	assign roll_angle = roll_q;
	assign corrected = apply_q;

	// one cordic step of a lane
	function automatic logic signed [CW+CW+ZW-1:0] rot(
		input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
		input logic signed [ZW-1:0] z, input logic [4:0] i);
		logic signed [CW-1:0] xs, ys, xn, yn;
		logic signed [ZW-1:0] zn;
		xs = x >>> i;
		ys = y >>> i;
		if (!y[CW-1]) begin
			xn = x + ys; yn = y - xs; zn = z + $signed(ctf_pkg::atan_tab(i));
		end else begin
			xn = x - ys; yn = y + xs; zn = z - $signed(ctf_pkg::atan_tab(i));
		end
		return {xn, yn, zn};
	endfunction

	// pre-rotation of a lane
	function automatic logic signed [CW+CW+ZW-1:0] pre(
		input logic signed [15:0] y16, input logic signed [15:0] x16);
		logic signed [CW-1:0] x, y;
		logic signed [ZW-1:0] z;
		x = CW'(x16) <<< 8;
		y = CW'(y16) <<< 8;
		z = '0;
		if (x16[15]) begin
			if (!y16[15]) begin
				z = 26'sd5898240; y = -x; x = CW'(y16) <<< 8;
			end else begin
				z = -26'sd5898240; y = x; x = -(CW'(y16) <<< 8);
			end
		end
		return {x, y, z};
	endfunction

	logic signed [CW+CW+ZW-1:0] prot, rrot, ppre, rpre;
	always_comb begin
		prot = rot(px_q, py_q, pz_q, cnt_q[4:0]);
		rrot = rot(rx_q, ry_q, rz_q, cnt_q[4:0]);
		ppre = pre(ay_q, az_q);
		rpre = pre(ax_q, az_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctf_pkg::ST_IDLE;
			cnt_q <= '0;
			gain_q <= 24'd655360;
			weight_q <= 17'd64225;
			low_q <= 17'd8192;
			high_q <= 17'd32768;
			pitch_q <= '0;
			roll_q <= '0;
			apply_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ctf_pkg::REG_GAIN: gain_q <= cfg_data;
					ctf_pkg::REG_WEIGHT: weight_q <= cfg_data[16:0];
					ctf_pkg::REG_LOW: low_q <= cfg_data[16:0];
					ctf_pkg::REG_HIGH: high_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			case (state_q)
				ctf_pkg::ST_IDLE: begin
					if (in_valid) begin
						state_q <= ctf_pkg::ST_GYRO;
						cnt_q <= '0;
					end
				end
				ctf_pkg::ST_GYRO: begin
					// 24 serial steps of rate * gain, then add into pitch and subtract from roll
					if (cnt_q == 6'd24) begin
						pitch_q <= ctf_pkg::sat32(64'(pitch_q) + 64'(pacc_q >>> 16));
						roll_q <= ctf_pkg::sat32(64'(roll_q) - 64'(racc_q >>> 16));
						apply_q <= ({1'b0, low_q} < mag) && (mag < {1'b0, high_q});
						cnt_q <= '0;
						if (({1'b0, low_q} < mag) && (mag < {1'b0, high_q}))
							state_q <= ctf_pkg::ST_CORD;
						else
							state_q <= ctf_pkg::ST_OUT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ctf_pkg::ST_CORD: begin
					if (cnt_q == 6'(NIter)) begin
						cnt_q <= '0;
						state_q <= ctf_pkg::ST_BLEND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ctf_pkg::ST_BLEND: begin
					if (cnt_q == 6'd17) begin
						pitch_q <= ctf_pkg::sat32(64'(pacc_q >>> 16));
						roll_q <= ctf_pkg::sat32(64'(racc_q >>> 16));
						state_q <= ctf_pkg::ST_OUT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ctf_pkg::ST_OUT: begin
					if (!out_stall) state_q <= ctf_pkg::ST_IDLE;
				end
				default: state_q <= ctf_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath: no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ctf_pkg::ST_IDLE: begin
				if (in_valid) begin
					ax_q <= accel_x; ay_q <= accel_y; az_q <= accel_z;
					gx_q <= rate_x; gy_q <= rate_y;
					msr_q <= gain_q;
					pacc_q <= '0;
					racc_q <= '0;
				end
			end
			ctf_pkg::ST_GYRO: begin
				if (cnt_q != 6'd24) begin
					// add rate << bit position when gain bit set
					if (msr_q[0]) begin
						pacc_q <= pacc_q + (49'(gx_q) <<< cnt_q[4:0]);
						racc_q <= racc_q + (49'(gy_q) <<< cnt_q[4:0]);
					end
					msr_q <= msr_q >> 1;
				end else begin
					{px_q, py_q, pz_q} <= ppre;
					{rx_q, ry_q, rz_q} <= rpre;
				end
			end
			ctf_pkg::ST_CORD: begin
				if (cnt_q != 6'(NIter)) begin
					{px_q, py_q, pz_q} <= prot;
					{rx_q, ry_q, rz_q} <= rrot;
				end else begin
					// zero inputs give zero angle
					if (ay_q == 16'sd0 && az_q == 16'sd0) pz_q <= '0;
					if (ax_q == 16'sd0 && az_q == 16'sd0) rz_q <= '0;
					wsr_q <= wsat;
					// seed with acc * (65536 - w), a narrow product
					pacc_q <= 49'(((az_q == 16'sd0 && ay_q == 16'sd0) ? 26'sd0 : pz_q) * wacc);
					racc_q <= 49'(((az_q == 16'sd0 && ax_q == 16'sd0) ? 26'sd0 : rz_q) * wacc);
				end
			end
			ctf_pkg::ST_BLEND: begin
				// serial angle * w, one weight bit per cycle
				if (cnt_q != 6'd17) begin
					if (wsr_q[0]) begin
						pacc_q <= pacc_q + (49'(pitch_q) <<< cnt_q[4:0]);
						racc_q <= racc_q + (49'(roll_q) <<< cnt_q[4:0]);
					end
					wsr_q <= wsr_q >> 1;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pitch_angle))
		else $error("result changed while stalled");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ctf_pkg::ST_GYRO)
		else $error("accepted item not started");
`endif

endmodule

[bench/tb_complementary_tilt_filter.sv]
module tb_complementary_tilt_filter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITERS = 16;
	localparam int ITEMS = 1000;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int HOLD_LEN = 600;

	// expected output of one sample
	typedef struct {
		logic signed [31:0] pitch;
		logic signed [31:0] roll;
		logic               corr;
	} tilt_t;

	// tilt predictor and queue of pending filter outputs
	class tilt_scoreboard;
		logic [23:0] gain;
		logic [16:0] weight;
		logic [16:0] thr_lo;
		logic [16:0] thr_hi;
		longint pitch_acc;
		longint roll_acc;
		tilt_t pending[$];
		int errors;
		int checked;
		int corr_seen;

		function void clear();
			gain = 24'd655360;
			weight = 17'd64225;
			thr_lo = 17'd8192;
			thr_hi = 17'd32768;
			pitch_acc = 0;
			roll_acc = 0;
		endfunction

		function longint floor_shift(longint v, int s);
			return v >>> s;
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint table_angle(int i);
			longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
				29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
				2, 1, 0};
			return t[i];
		endfunction

		// vectoring cordic, result in q16 degrees
		function longint tilt_atan2(longint y, longint x);
			longint z, t, xs, ys;
			int n;
			n = ITERS > 24 ? 24 : ITERS;
			z = 0;
			if (x == 0 && y == 0) return 0;
			x = x * 256;
			y = y * 256;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = 90 * 65536;
				end else begin
					t = x; x = -y; y = t; z = -90 * 65536;
				end
			end
			for (int i = 0; i < n; i++) begin
				xs = floor_shift(x, i);
				ys = floor_shift(y, i);
				if (y >= 0) begin
					x = x + ys; y = y - xs; z += table_angle(i);
				end else begin
					x = x - ys; y = y + xs; z -= table_angle(i);
				end
			end
			return z;
		endfunction

		function longint mix(longint ang, longint acc, longint w);
			return clip32(floor_shift(ang * w + acc * (65536 - w), 16));
		endfunction

		function void write_reg(logic [1:0] idx, logic [23:0] val);
			case (idx)
				ctf_pkg::REG_GAIN: gain = val;
				ctf_pkg::REG_WEIGHT: weight = val[16:0];
				ctf_pkg::REG_LOW: thr_lo = val[16:0];
				ctf_pkg::REG_HIGH: thr_hi = val[16:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
				logic signed [15:0] az, logic signed [15:0] gx, logic signed [15:0] gy);
			longint g, m, w;
			tilt_t e;
			g = gain;
			pitch_acc = clip32(pitch_acc + floor_shift(longint'(gx) * g, 16));
			roll_acc = clip32(roll_acc - floor_shift(longint'(gy) * g, 16));
			m = (ax < 0 ? -longint'(ax) : longint'(ax)) + (ay < 0 ? -longint'(ay) : longint'(ay))
				+ (az < 0 ? -longint'(az) : longint'(az));
			e.corr = (m > longint'(thr_lo)) && (m < longint'(thr_hi));
			if (e.corr) begin
				w = weight > 65536 ? 65536 : weight;
				pitch_acc = mix(pitch_acc, tilt_atan2(ay, az), w);
				roll_acc = mix(roll_acc, tilt_atan2(ax, az), w);
			end
			e.pitch = pitch_acc[31:0];
			e.roll = roll_acc[31:0];
			pending.push_back(e);
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("mismatch %0d: %s", errors, msg);
		endtask

		task check_output(logic signed [31:0] p, logic signed [31:0] r, logic c);
			tilt_t e;
			checked++;
			if (c) corr_seen++;
			if (pending.size() == 0) begin
				report_mismatch("output with nothing pending");
				return;
			end
			e = pending.pop_front();
			if (p !== e.pitch)
				report_mismatch($sformatf("pitch got %0d want %0d", p, e.pitch));
			if (r !== e.roll)
				report_mismatch($sformatf("roll got %0d want %0d", r, e.roll));
			if (c !== e.corr)
				report_mismatch($sformatf("corrected got %0b want %0b", c, e.corr));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] accel_x = 0, accel_y = 0, accel_z = 0, rate_x = 0, rate_y = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] pitch_angle, roll_angle;
	logic corrected;
	logic cfg_we = 0;
	logic [1:0] cfg_index = ctf_pkg::REG_GAIN;
	logic [23:0] cfg_data = 0;

	tilt_scoreboard sb = new();
	int send_idle_pct = 0;    // chance the sender idles, percent
	int recv_stall_pct = 0;   // chance the receiver stalls, percent
	bit hold_req = 0;         // toggled to ask for a long receiver hold-off
	bit hold_ack = 0;
	int hold_cycles = 0;      // hold-off cycles left
	longint cycles = 0;
	int sent = 0;

	complementary_tilt_filter #(.ATAN_ITERATIONS(ITERS)) u_top (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver: random stalls, or a long counted hold-off
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_output(pitch_angle, roll_angle, corrected);
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cycles <= HOLD_LEN;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL complementary_tilt_filter");
			$finish;
		end
	end

	// offer one sample and hold it until accepted
	task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
			logic [15:0] gx, logic [15:0] gy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		accel_x <= ax; accel_y <= ay; accel_z <= az; rate_x <= gx; rate_y <= gy;
		do @(posedge clk); while (in_stall);
		sb.note_sample(ax, ay, az, gx, gy);
		sent++;
	endtask

	// wait for every pending output, then let the block settle
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// accel vector with magnitude sum aimed near the correction window
	task automatic send_random();
		logic [15:0] ax, ay, az;
		int k;
		k = $urandom_range(9);
		if (k < 6) begin
			ax = 16'($urandom_range(0, 12000) - 6000);
			ay = 16'($urandom_range(0, 12000) - 6000);
			az = 16'($urandom_range(0, 40000) - 20000);
		end else begin
			ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
		end
		if ($urandom_range(19) == 0) begin ax = 0; ay = 0; az = 0; end
		if ($urandom_range(3) == 0)
			send_sample(ax, ay, az, 16'($urandom), 16'($urandom));
		else
			send_sample(ax, ay, az, 16'($urandom_range(0, 400) - 200),
				16'($urandom_range(0, 400) - 200));
	endtask

	task automatic random_config();
		case ($urandom_range(3))
			0: write_reg(ctf_pkg::REG_GAIN, 24'($urandom));
			1: write_reg(ctf_pkg::REG_WEIGHT, 24'($urandom_range(0, 131071)));
			2: write_reg(ctf_pkg::REG_LOW, 24'($urandom_range(0, 98304)));
			3: write_reg(ctf_pkg::REG_HIGH, 24'($urandom_range(0, 98304)));
			default: ;
		endcase
	endtask

	initial begin
		sb.clear();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, zero vector, axis signs
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h1000, 16'h3000, 16'h7fff, 16'h8000);
		send_sample(16'h1000, 16'h0000, 16'hd000, 16'h8000, 16'h7fff);
		send_sample(16'hf000, 16'hf000, 16'hd000, 16'h0001, 16'hffff);
		send_sample(16'h0800, 16'hf800, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h5555, 16'haaaa);
		send_sample(16'h8000, 16'h8000, 16'h8000, 16'haaaa, 16'h5555);
		send_sample(16'hffff, 16'h2000, 16'hffff, 16'hffff, 16'h0001);
		drain();
		// max gain, full gyro weight, unordered thresholds
		write_reg(ctf_pkg::REG_GAIN, 24'hffffff);
		write_reg(ctf_pkg::REG_WEIGHT, 24'h1ffff);
		write_reg(ctf_pkg::REG_LOW, 24'd98304);
		write_reg(ctf_pkg::REG_HIGH, 24'd0);
		repeat (6) send_sample(16'h1000, 16'h1000, 16'h1000, 16'h7fff, 16'h8000);
		repeat (6) send_sample(16'h1000, 16'h1000, 16'h1000, 16'h8000, 16'h7fff);
		drain();
		// accel only, widest window
		write_reg(ctf_pkg::REG_GAIN, 24'd0);
		write_reg(ctf_pkg::REG_WEIGHT, 24'd0);
		write_reg(ctf_pkg::REG_LOW, 24'd0);
		write_reg(ctf_pkg::REG_HIGH, 24'd98304);
		send_sample(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0001, 16'hffff, 16'hffff, 16'h0000, 16'h0000);
		send_sample(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
		drain();

		// random phases over idling mixes with config changes between
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				3: begin send_idle_pct = 25; recv_stall_pct = 25; end
				default: ;
			endcase
			if (ph == 0) begin
				write_reg(ctf_pkg::REG_GAIN, 24'd655360);
				write_reg(ctf_pkg::REG_WEIGHT, 24'd64225);
				write_reg(ctf_pkg::REG_LOW, 24'd8192);
				write_reg(ctf_pkg::REG_HIGH, 24'd32768);
			end else if (ph == 4) begin
				write_reg(ctf_pkg::REG_WEIGHT, 24'd65536);
				write_reg(ctf_pkg::REG_HIGH, 24'd98304);
			end else begin
				random_config();
				random_config();
			end
			if (ph == 2) hold_req <= !hold_req; // block fills and stalls its input
			repeat (120) send_random();
			drain();  // sender pauses until everything has come back
		end

		send_idle_pct = 0; recv_stall_pct = 0;
		drain();
		$display("sent %0d samples, checked %0d outputs, %0d with accel correction",
			sent, sb.checked, sb.corr_seen);
		$display("covered max gyro gain, blend weight extremes and four idling mixes");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS complementary_tilt_filter");
		else
			$display("FAIL complementary_tilt_filter");
		$finish;
	end
endmodule
